@@ design/tcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcfc_pkg
// Shared widths, opcodes, controller states and the command/status structs
// that join the circle fill controller and its datapath.
// ----------------------------------------------------------------------------
package tcfc_pkg;

    // Defaults for the top level parameters
    localparam int CANVAS_SIDE_DEF = 64;
    localparam int FRAC_BITS_DEF   = 12;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int CRD_W   = 18;
    localparam int RAD_W   = 17;
    localparam int COLOR_W = 4;
    localparam int IDX_W   = 9;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 13;

    typedef enum logic [OP_W-1:0] {
        OP_FILL  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_START,
        S_SQX,
        S_SQY,
        S_PAINT,
        S_WIPE,
        S_LOAD,
        S_DONE
    } state_t;

    // Operand choice of the shared squaring multiplier
    typedef enum logic [1:0] {
        MUL_R,
        MUL_DX,
        MUL_DY
    } mul_sel_t;

    typedef struct packed {
        logic     capture;     // latch the input transaction
        logic     wipe;        // clear one canvas word, zero the counters
        logic     setup;       // latch r^2 and the clipped box
        mul_sel_t mul_sel;
        logic     start;       // load x/y walk counters
        logic     sqx_we;
        logic     sqy_we;
        logic     paint;       // test, write pixel, count, step
        logic     load_sub;    // wrap reference index once
        logic     load_write;  // write reference word
        logic     out_load;    // snapshot counters into result register
    } cmd_t;

    typedef struct packed {
        logic empty;      // clipped box holds no pixel
        logic last_pix;   // walk at final pixel of box
        logic wipe_last;  // sweep at final canvas word
        logic idx_wrap;   // reference index still out of range
    } status_t;

endpackage

@@ design/tiled_circle_fill_counter.sv @@
// ----------------------------------------------------------------------------
// tiled_circle_fill_counter
// Filled circle painter over two tiled 4-bit canvases with painted and
// reference-match counters.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  item     | item_valid / item_stall    | opcode, canvas_sel, center_x/y,
//           |                            | radius, color, count_enable,
//           |                            | word_index, word_data
//  result   | result_valid / result_stall| painted_count, correct_count
//
//  Per transaction: fill squares the radius, then per pixel of the clipped box
//  forms dx^2 and dy^2 through one shared multiplier, then does a canvas
//  read-modify-write; clear zeroes all 2*CANVAS_SIDE^2/8 words of both canvases,
//  one canvas word per cycle; load wraps the index into range, then writes.
//  After reset the same sweep zeroes both canvases, with item_stall high
//  and no result issued.
//  One transaction is worked at a time; the next one is taken while a result
//  still sits in the result register, and the block holds at completion
//  only when that register is still occupied and stalled.
// ----------------------------------------------------------------------------
module tiled_circle_fill_counter
    import tcfc_pkg::*;
#(
    parameter int CANVAS_SIDE = CANVAS_SIDE_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [OP_W-1:0]    opcode,
    input  logic               canvas_sel,
    input  logic [CRD_W-1:0]   center_x,
    input  logic [CRD_W-1:0]   center_y,
    input  logic [RAD_W-1:0]   radius,
    input  logic [COLOR_W-1:0] color,
    input  logic               count_enable,
    input  logic [IDX_W-1:0]   word_index,
    input  logic [WORD_W-1:0]  word_data,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [CNT_W-1:0]   painted_count,
    output logic [CNT_W-1:0]   correct_count
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: clear sweeps, reference load wrap, per-pixel fill walk
    tcfc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // Datapath: box clip, squarer, canvas/reference memories, counters
    tcfc_dpath #(
        .CANVAS_SIDE (CANVAS_SIDE),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .canvas_sel    (canvas_sel),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .color         (color),
        .count_enable  (count_enable),
        .word_index    (word_index),
        .word_data     (word_data),
        .painted_count (painted_count),
        .correct_count (correct_count)
    );

endmodule

@@ design/tcfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcfc_ctrl
// Controller: sequences clear sweeps, reference loads and the per-pixel
// fill walk, and owns both handshakes.
// ----------------------------------------------------------------------------
module tcfc_ctrl
    import tcfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  logic [OP_W-1:0] opcode,
    output logic          result_valid,
    input  logic          result_stall,
    output cmd_t          cmd,
    input  status_t       status
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (status.wipe_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (op_t'(opcode))
                        OP_FILL:  state_next = S_SETUP;
                        OP_CLEAR: state_next = S_WIPE;
                        OP_LOAD:  state_next = S_LOAD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_SETUP: state_next = S_START;
            S_START: state_next = status.empty ? S_DONE : S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_PAINT;
            S_PAINT: state_next = status.last_pix ? S_DONE : S_SQX;
            S_WIPE:
            begin
                if (status.wipe_last)
                    state_next = S_DONE;
            end
            S_LOAD:
            begin
                if (!status.idx_wrap)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_R;
        item_stall  = 1'b1;
        case (state_reg)
            S_INIT:  cmd.wipe = 1'b1;
            S_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            S_SETUP:
            begin
                cmd.setup   = 1'b1;
                cmd.mul_sel = MUL_R;
            end
            S_START: cmd.start = 1'b1;
            S_SQX:
            begin
                cmd.mul_sel = MUL_DX;
                cmd.sqx_we  = 1'b1;
            end
            S_SQY:
            begin
                cmd.mul_sel = MUL_DY;
                cmd.sqy_we  = 1'b1;
            end
            S_PAINT: cmd.paint = 1'b1;
            S_WIPE:  cmd.wipe = 1'b1;
            S_LOAD:
            begin
                cmd.load_sub   = status.idx_wrap;
                cmd.load_write = !status.idx_wrap;
            end
            S_DONE:  cmd.out_load = !out_valid_reg || !result_stall;
            default: item_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;

endmodule

@@ design/tcfc_dpath.sv @@
// ----------------------------------------------------------------------------
// tcfc_dpath
// Datapath: transaction registers, box clipping, shared squaring multiplier,
// tiled canvas and reference memories, saturating counters, result register.
// ----------------------------------------------------------------------------
module tcfc_dpath
    import tcfc_pkg::*;
#(
    parameter int CANVAS_SIDE = CANVAS_SIDE_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               canvas_sel,
    input  logic [CRD_W-1:0]   center_x,
    input  logic [CRD_W-1:0]   center_y,
    input  logic [RAD_W-1:0]   radius,
    input  logic [COLOR_W-1:0] color,
    input  logic               count_enable,
    input  logic [IDX_W-1:0]   word_index,
    input  logic [WORD_W-1:0]  word_data,
    output logic [CNT_W-1:0]   painted_count,
    output logic [CNT_W-1:0]   correct_count
);

    localparam int XW    = $clog2(CANVAS_SIDE);
    localparam int TPR   = CANVAS_SIDE / 8;
    localparam int WORDS = CANVAS_SIDE * CANVAS_SIDE / 8;
    localparam int AW    = $clog2(WORDS);
    localparam int MW    = AW + 1;
    localparam int TW    = (AW > 3) ? AW - 3 : 1;
    localparam int PW    = XW + FRAC_BITS;
    localparam int DW    = (PW > CRD_W) ? PW : CRD_W;
    localparam int SQW   = 2 * DW - FRAC_BITS;
    localparam int BW    = CRD_W + 1;
    localparam int IXW   = ((IDX_W > AW) ? IDX_W : AW) + 1;

    // Transaction registers
    logic               sel_reg;
    logic [CRD_W-1:0]   cx_reg;
    logic [CRD_W-1:0]   cy_reg;
    logic [RAD_W-1:0]   r_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               cnt_en_reg;
    logic [IXW-1:0]     idx_reg;
    logic [WORD_W-1:0]  data_reg;

    // Box and walk
    logic [XW-1:0]  xs_reg, xe_reg, ys_reg, ye_reg;
    logic [XW-1:0]  x_reg, y_reg;
    logic           empty_reg;
    logic [SQW-1:0] r2_reg, sqx_reg, sqy_reg;

    // Memories
    logic [WORD_W-1:0] canvas_mem [0:2**MW-1];
    logic [WORD_W-1:0] ref_mem [0:WORDS-1];
    logic [WORD_W-1:0] canvas_rd_reg;
    logic [WORD_W-1:0] ref_rd_reg;

    logic [MW-1:0]    wipe_reg;
    logic [CNT_W-1:0] painted_reg, correct_reg;
    logic [CNT_W-1:0] painted_out_reg, correct_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sel_reg    <= canvas_sel;
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            r_reg      <= radius;
            color_reg  <= color;
            cnt_en_reg <= count_enable;
            idx_reg    <= IXW'(word_index);
            data_reg   <= word_data;
        end
        else if (cmd.load_sub)
        begin
            idx_reg <= idx_reg - IXW'(WORDS);
        end
    end

    // Clipped bounding box, pixel units
    logic [BW-1:0] cxw, cyw, rw;
    logic [BW-1:0] lox_fx, hix_fx, loy_fx, hiy_fx;
    logic [BW-1:0] lox, hix, loy, hiy, hix_c, hiy_c;
    logic          empty;

    always_comb
    begin
        cxw    = BW'(cx_reg);
        cyw    = BW'(cy_reg);
        rw     = BW'(r_reg);
        lox_fx = (cxw >= rw) ? cxw - rw : '0;
        loy_fx = (cyw >= rw) ? cyw - rw : '0;
        hix_fx = cxw + rw;
        hiy_fx = cyw + rw;
        lox    = lox_fx >> FRAC_BITS;
        loy    = loy_fx >> FRAC_BITS;
        hix    = hix_fx >> FRAC_BITS;
        hiy    = hiy_fx >> FRAC_BITS;
        hix_c  = (hix > BW'(CANVAS_SIDE - 1)) ? BW'(CANVAS_SIDE - 1) : hix;
        hiy_c  = (hiy > BW'(CANVAS_SIDE - 1)) ? BW'(CANVAS_SIDE - 1) : hiy;
        empty  = (lox > hix_c) || (loy > hiy_c);
    end

    // Shared squarer: |d|^2 truncated by FRAC_BITS
    logic [DW-1:0]   px_fx, py_fx, cx_ext, cy_ext, dx_abs, dy_abs, mul_op;
    logic [2*DW-1:0] prod;
    logic [SQW-1:0]  sq;

    always_comb
    begin
        px_fx  = DW'({x_reg, {FRAC_BITS{1'b0}}});
        py_fx  = DW'({y_reg, {FRAC_BITS{1'b0}}});
        cx_ext = DW'(cx_reg);
        cy_ext = DW'(cy_reg);
        dx_abs = (px_fx >= cx_ext) ? px_fx - cx_ext : cx_ext - px_fx;
        dy_abs = (py_fx >= cy_ext) ? py_fx - cy_ext : cy_ext - py_fx;
        case (cmd.mul_sel)
            MUL_R:   mul_op = DW'(r_reg);
            MUL_DX:  mul_op = dx_abs;
            MUL_DY:  mul_op = dy_abs;
            default: mul_op = '0;
        endcase
        prod = mul_op * mul_op;
        sq   = SQW'(prod >> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            r2_reg    <= sq;
            xs_reg    <= lox[XW-1:0];
            xe_reg    <= hix_c[XW-1:0];
            ys_reg    <= loy[XW-1:0];
            ye_reg    <= hiy_c[XW-1:0];
            empty_reg <= empty;
        end
        if (cmd.sqx_we)
            sqx_reg <= sq;
        if (cmd.sqy_we)
            sqy_reg <= sq;
        // x outer, y inner
        if (cmd.start)
        begin
            x_reg <= xs_reg;
            y_reg <= ys_reg;
        end
        else if (cmd.paint)
        begin
            if (y_reg == ye_reg)
            begin
                y_reg <= ys_reg;
                x_reg <= x_reg + 1'b1;
            end
            else
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    // Tiled word address: ((y/8)*TPR + x/8)*8 + y%8
    logic [XW-1:0] xt, yt;
    logic [TW-1:0] tile;
    logic [AW-1:0] word_addr;

    always_comb
    begin
        xt        = x_reg >> 3;
        yt        = y_reg >> 3;
        tile      = TW'(32'(yt) * TPR + 32'(xt));
        word_addr = AW'({tile, y_reg[2:0]});
    end

    // Pixel test and nibble update
    logic [SQW:0]        dist_sum;
    logic                in_circle;
    logic [4:0]          sh;
    logic [WORD_W-1:0]   mask, new_word;
    logic [COLOR_W-1:0]  old_nib, ref_nib;

    always_comb
    begin
        dist_sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        in_circle = dist_sum <= {1'b0, r2_reg};
        sh        = {x_reg[2:0], 2'b00};
        mask      = WORD_W'(4'hF) << sh;
        old_nib   = COLOR_W'(canvas_rd_reg >> sh);
        ref_nib   = COLOR_W'(ref_rd_reg >> sh);
        new_word  = (canvas_rd_reg & ~mask) | (WORD_W'(color_reg) << sh);
    end

    logic              cv_we;
    logic [MW-1:0]     cv_waddr;
    logic [WORD_W-1:0] cv_wdata;

    assign cv_we    = cmd.wipe || (cmd.paint && in_circle);
    assign cv_waddr = cmd.wipe ? wipe_reg : {sel_reg, word_addr};
    assign cv_wdata = cmd.wipe ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (cv_we)
            canvas_mem[cv_waddr] <= cv_wdata;
        canvas_rd_reg <= canvas_mem[{sel_reg, word_addr}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
            ref_mem[idx_reg[AW-1:0]] <= data_reg;
        ref_rd_reg <= ref_mem[word_addr];
    end

    // Clear sweep address and saturating counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_reg    <= '0;
            painted_reg <= '0;
            correct_reg <= '0;
        end
        else if (cmd.wipe)
        begin
            wipe_reg    <= wipe_reg + 1'b1;
            painted_reg <= '0;
            correct_reg <= '0;
        end
        else if (cmd.paint && in_circle && cnt_en_reg && (old_nib == '0))
        begin
            if (painted_reg != '1)
                painted_reg <= painted_reg + 1'b1;
            if ((ref_nib == color_reg) && (correct_reg != '1))
                correct_reg <= correct_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            painted_out_reg <= painted_reg;
            correct_out_reg <= correct_reg;
        end
    end

    assign painted_count = painted_out_reg;
    assign correct_count = correct_out_reg;

    assign status.empty     = empty_reg;
    assign status.last_pix  = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign status.wipe_last = (wipe_reg == '1);
    assign status.idx_wrap  = (idx_reg >= IXW'(WORDS));

endmodule
